### rtl/core/drsp_pkg.sv
// Shared constants and types of the 3x3 range image despeckle filter.
// Used by drsp_front, drsp_back and the top level; depends on nothing.
package drsp_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int QUEUE_DEPTH   = 4;

    localparam int PIX_W  = 16;
    localparam int WREG_W = 11;
    localparam int HREG_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [PIX_W-1:0]  THRESH_RST = 16'd256;
    localparam logic [WREG_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [HREG_W-1:0] HEIGHT_RST = 16'd480;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // request codes
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // per-job flags from the front to the back
    typedef struct packed {
        logic inner;
        logic last;
    } job_tag_t;

endpackage

### rtl/core/drsp_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
module drsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/drsp_queue.sv
// Small job queue between the front and the back of the despeckle filter.
// Depends on nothing.
module drsp_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] din,
    input  logic          pop,
    output logic [DW-1:0] dout,
    output logic          full,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DW-1:0]    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("job queue underflow");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("job queue count out of range");

endmodule

### rtl/core/drsp_front.sv
// Front of the despeckle filter: configuration, history writes, pending
// count, output raster position and job classification. Uses drsp_pkg.
module drsp_front #(
    parameter int MAX_WIDTH = drsp_pkg::MAX_WIDTH_DEF,
    parameter int AW        = 12,
    parameter int WW        = 11,
    parameter int PW        = 11
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [drsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [drsp_pkg::PIX_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [drsp_pkg::PIX_W-1:0]        pixel_in,
    input  logic                              stall,
    input  logic                              q_full,
    output logic                              q_push,
    output logic [AW-1:0]                     q_addr,
    output drsp_pkg::job_tag_t                q_tag,
    output logic                              mem_we,
    output logic [AW-1:0]                     mem_waddr,
    output logic [drsp_pkg::PIX_W-1:0]        mem_wdata,
    output logic [WW-1:0]                     eff_width,
    output logic [drsp_pkg::PIX_W-1:0]        eff_thresh
);

    logic [drsp_pkg::PIX_W-1:0]  thresh_reg;
    logic [drsp_pkg::WREG_W-1:0] width_reg;
    logic [drsp_pkg::HREG_W-1:0] height_reg;
    logic [PW-1:0]               pending_reg;
    logic [AW-1:0]               wr_reg;
    logic [WW-1:0]               ocol_reg;
    logic [drsp_pkg::HREG_W-1:0] orow_reg;

    logic [drsp_pkg::HREG_W-1:0] eff_h;
    logic [PW-1:0]               w_plus1;
    logic                        accept, is_flush, full_pend, emit, border, at_last;
    logic                        row_last, col_last, cfg_hit;

    always_comb
    begin
        if (width_reg < 11'd3)
        begin
            eff_width = WW'(3);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            eff_width = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = WW'(width_reg);
        end
    end

    assign eff_h      = (height_reg < 16'd3) ? 16'd3 : height_reg;
    assign eff_thresh = (thresh_reg == '0) ? 16'd1 : thresh_reg;
    assign w_plus1    = PW'(eff_width) + 1'b1;

    assign in_ready  = !q_full && !stall;
    assign accept    = in_valid && in_ready;
    assign is_flush  = (req_type == drsp_pkg::REQ_FLUSH);
    assign full_pend = !(pending_reg < w_plus1);
    assign emit      = accept && (is_flush ? (pending_reg != '0) : full_pend);

    assign row_last = (orow_reg == eff_h - 1'b1);
    assign col_last = (ocol_reg == eff_width - 1'b1);
    assign border   = (orow_reg == '0) || row_last || (ocol_reg == '0) || col_last;
    assign at_last  = row_last && col_last;

    assign q_push      = emit;
    assign q_tag.inner = !is_flush && !border;
    assign q_tag.last  = at_last;
    // center of the emitted pixel: oldest pending, or w+1 back from the new pixel
    assign q_addr = is_flush ? (wr_reg - AW'(pending_reg))
                             : (wr_reg - AW'(eff_width) - 1'b1);

    assign mem_we    = accept && !is_flush;
    assign mem_waddr = wr_reg;
    assign mem_wdata = pixel_in;

    assign cfg_hit = cfg_valid && ((cfg_index == drsp_pkg::CFG_THRESH) ||
                                   (cfg_index == drsp_pkg::CFG_WIDTH) ||
                                   (cfg_index == drsp_pkg::CFG_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg  <= drsp_pkg::THRESH_RST;
            width_reg   <= drsp_pkg::WIDTH_RST;
            height_reg  <= drsp_pkg::HEIGHT_RST;
            pending_reg <= '0;
            wr_reg      <= '0;
            ocol_reg    <= '0;
            orow_reg    <= '0;
        end
        else if (cfg_hit)
        begin
            unique case (cfg_index)
                drsp_pkg::CFG_THRESH: thresh_reg <= cfg_data;
                drsp_pkg::CFG_WIDTH:  width_reg  <= cfg_data[drsp_pkg::WREG_W-1:0];
                default:              height_reg <= cfg_data;
            endcase
            // restart the frame, drop delayed pixels
            pending_reg <= '0;
            ocol_reg    <= '0;
            orow_reg    <= '0;
        end
        else if (accept)
        begin
            if (!is_flush)
            begin
                wr_reg <= wr_reg + 1'b1;
                if (!full_pend)
                begin
                    pending_reg <= pending_reg + 1'b1;
                end
            end
            else if (pending_reg != '0)
            begin
                pending_reg <= pending_reg - 1'b1;
            end
            if (emit)
            begin
                if (col_last)
                begin
                    ocol_reg <= '0;
                    orow_reg <= row_last ? '0 : orow_reg + 1'b1;
                end
                else
                begin
                    ocol_reg <= ocol_reg + 1'b1;
                end
            end
        end
    end

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= w_plus1)
        else $error("pending count above width plus one");
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ocol_reg < eff_width)
        else $error("output column out of range");
    a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_flush && (pending_reg == '0)) |=> (pending_reg == '0))
        else $error("flush on empty pipe changed pending count");

endmodule

### rtl/core/drsp_back.sv
// Back of the despeckle filter: reads the 3x3 window from history, finds
// neighbor min/max, corrects by a serial remainder, writes back, holds result.
// Uses drsp_pkg.
module drsp_back #(
    parameter int AW = 12,
    parameter int WW = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [drsp_pkg::PIX_W-1:0]  eff_thresh,
    input  logic [WW-1:0]               eff_width,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  logic [AW-1:0]               q_addr,
    input  drsp_pkg::job_tag_t          q_tag,
    output logic [AW-1:0]               mem_raddr,
    input  logic [drsp_pkg::PIX_W-1:0]  mem_rdata,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [drsp_pkg::PIX_W-1:0]  mem_wdata,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [drsp_pkg::PIX_W-1:0]  pixel_out,
    output logic                        frame_last
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_DIV  = 5'b00100,
        S_WB   = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t                      state_reg;
    logic [3:0]                  k_reg;
    logic [3:0]                  cnt_reg;
    logic [AW-1:0]               c_reg;
    drsp_pkg::job_tag_t          tag_reg;
    logic [drsp_pkg::PIX_W-1:0]  me_reg, mn_reg, mx_reg;
    logic [drsp_pkg::PIX_W-1:0]  base_reg, rem_reg, dvd_reg, res_reg;
    logic                        up_reg;
    logic                        out_valid_reg;
    logic [drsp_pkg::PIX_W-1:0]  pixel_reg;
    logic                        last_reg;

    logic [AW-1:0]               row_addr, win_addr, w_aw;
    logic [3:0]                  idx;
    logic                        take_me;
    logic [drsp_pkg::PIX_W-1:0]  mn_next, mx_next, rem_next, res_calc;
    logic [drsp_pkg::PIX_W:0]    trial;
    logic                        up_hit, dn_hit;
    logic                        load_out;

    assign w_aw = AW'(eff_width);

    always_comb
    begin
        case (k_reg) inside
            4'd0, 4'd1, 4'd2: row_addr = c_reg - w_aw;
            4'd3, 4'd4, 4'd5: row_addr = c_reg;
            default:          row_addr = c_reg + w_aw;
        endcase
        case (k_reg) inside
            4'd0, 4'd3, 4'd6: win_addr = row_addr - 1'b1;
            4'd1, 4'd4, 4'd7: win_addr = row_addr;
            default:          win_addr = row_addr + 1'b1;
        endcase
    end

    assign mem_raddr = tag_reg.inner ? win_addr : c_reg;

    // data on the read port belongs to the address issued in the previous cycle
    assign idx     = k_reg - 1'b1;
    assign take_me = !tag_reg.inner || (idx == 4'd4);

    always_comb
    begin
        mn_next = mn_reg;
        mx_next = mx_reg;
        if (state_reg == S_IDLE)
        begin
            mn_next = '1;
            mx_next = '0;
        end
        else if ((state_reg == S_READ) && (k_reg != '0) && !take_me)
        begin
            if (mem_rdata < mn_reg)
            begin
                mn_next = mem_rdata;
            end
            if (mem_rdata > mx_reg)
            begin
                mx_next = mem_rdata;
            end
        end
    end

    assign up_hit = (mn_next > me_reg) && ((mn_next - me_reg) > eff_thresh);
    assign dn_hit = (me_reg > mx_next) && ((me_reg - mx_next) > eff_thresh);

    assign trial    = {rem_reg, dvd_reg[drsp_pkg::PIX_W-1]};
    assign rem_next = (trial >= {1'b0, eff_thresh}) ? drsp_pkg::PIX_W'(trial - {1'b0, eff_thresh})
                                                    : trial[drsp_pkg::PIX_W-1:0];
    assign res_calc = up_reg ? (base_reg - rem_reg) : (base_reg + rem_reg);

    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign mem_we    = (state_reg == S_WB);
    assign mem_waddr = c_reg;
    assign mem_wdata = res_calc;

    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_reg;
    assign frame_last = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (!tag_reg.inner && (k_reg == 4'd1))
                    begin
                        state_reg <= S_OUT;
                    end
                    else if (k_reg == 4'd9)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (up_hit || dn_hit) ? S_DIV : S_WB;
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 4'd15)
                    begin
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        mn_reg <= mn_next;
        mx_reg <= mx_next;
        unique case (state_reg)
            S_IDLE:
            begin
                c_reg   <= q_addr;
                tag_reg <= q_tag;
            end
            S_READ:
            begin
                if ((k_reg != '0) && take_me)
                begin
                    me_reg <= mem_rdata;
                end
                if (!tag_reg.inner && (k_reg == 4'd1))
                begin
                    res_reg <= mem_rdata;
                end
                if (k_reg == 4'd9)
                begin
                    rem_reg <= '0;
                    up_reg  <= up_hit;
                    if (up_hit)
                    begin
                        dvd_reg  <= mn_next - me_reg - 1'b1;
                        base_reg <= mn_next - 1'b1;
                    end
                    else if (dn_hit)
                    begin
                        dvd_reg  <= me_reg - mx_next - 1'b1;
                        base_reg <= mx_next + 1'b1;
                    end
                    else
                    begin
                        dvd_reg  <= '0;
                        base_reg <= me_reg;
                    end
                end
            end
            S_DIV:
            begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[drsp_pkg::PIX_W-2:0], 1'b0};
            end
            S_WB:
            begin
                res_reg <= res_calc;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    pixel_reg <= res_reg;
                    last_reg  <= tag_reg.last;
                end
            end
            default:
            begin
            end
        endcase
    end

    a_rem_below_thresh: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < eff_thresh))
        else $error("remainder not below threshold");
    a_full_window_inner: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_READ) && (k_reg == 4'd9)) |-> tag_reg.inner)
        else $error("window read on a pass-through job");
    a_load_after_free: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && out_valid_reg && !out_ready) |=> (state_reg == S_OUT))
        else $error("result left while output register busy");

endmodule

### rtl/core/range_image_despeckle_3x3.sv
// Top level of the streaming 3x3 range image despeckle filter.
// Depends on drsp_pkg, drsp_front, drsp_queue, drsp_back, drsp_ram.
//
//   port group | direction | handshake            | payload
//   -----------+-----------+----------------------+----------------------------
//   in         | sink      | in_valid / in_ready  | req_type, pixel_in
//   out        | source    | out_valid/out_ready  | pixel_out, frame_last
//   cfg        | sink      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Border and flush items pass their center through the back; inner pixels take
// nine window reads on the single history read port, then write-back, with a
// 16-step serial remainder against the threshold first if corrected.
// The front accepts one item a cycle until the 4-entry job queue fills. Reset
// is asynchronous, active low; history contents are not cleared. in_ready drops
// while the queue is full or the back writes an inner result into history.
module range_image_despeckle_3x3 #(
    parameter int MAX_WIDTH = drsp_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic [drsp_pkg::PIX_W-1:0]      pixel_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [drsp_pkg::PIX_W-1:0]      pixel_out,
    output logic                            frame_last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [drsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [drsp_pkg::PIX_W-1:0]      cfg_data
);

    // history must cover two lines plus the window and the items in flight
    localparam int AW = $clog2(2 * MAX_WIDTH + 3 + 2 * drsp_pkg::QUEUE_DEPTH + 4);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);
    localparam int TAG_W = $bits(drsp_pkg::job_tag_t);
    localparam int QW = AW + TAG_W;

    logic                       q_push, q_pop, q_full, q_empty;
    logic [AW-1:0]              f_addr, b_addr;
    drsp_pkg::job_tag_t         f_tag, b_tag;
    logic [QW-1:0]              q_dout;
    logic                       f_we, b_we;
    logic [AW-1:0]              f_waddr, b_waddr, raddr, ram_waddr;
    logic [drsp_pkg::PIX_W-1:0] f_wdata, b_wdata, rdata, ram_wdata;
    logic [WW-1:0]              eff_width;
    logic [drsp_pkg::PIX_W-1:0] eff_thresh;

    assign cfg_ready = 1'b1;

    drsp_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW),
        .WW        (WW),
        .PW        (PW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .pixel_in   (pixel_in),
        .stall      (b_we),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_addr     (f_addr),
        .q_tag      (f_tag),
        .mem_we     (f_we),
        .mem_waddr  (f_waddr),
        .mem_wdata  (f_wdata),
        .eff_width  (eff_width),
        .eff_thresh (eff_thresh)
    );

    drsp_queue #(
        .DW    (QW),
        .DEPTH (drsp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   ({f_tag, f_addr}),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    assign b_addr = q_dout[AW-1:0];
    assign b_tag  = drsp_pkg::job_tag_t'(q_dout[QW-1:AW]);

    drsp_back #(
        .AW (AW),
        .WW (WW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .eff_thresh (eff_thresh),
        .eff_width  (eff_width),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_addr     (b_addr),
        .q_tag      (b_tag),
        .mem_raddr  (raddr),
        .mem_rdata  (rdata),
        .mem_we     (b_we),
        .mem_waddr  (b_waddr),
        .mem_wdata  (b_wdata),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .frame_last (frame_last)
    );

    // the back's write-back wins the port; the front is held off that cycle
    assign ram_waddr = b_we ? b_waddr : f_waddr;
    assign ram_wdata = b_we ? b_wdata : f_wdata;

    drsp_ram #(
        .WIDTH (drsp_pkg::PIX_W),
        .DEPTH (1 << AW)
    ) u_hist (
        .clk   (clk),
        .we    (b_we || f_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n) !(b_we && f_we))
        else $error("front and back write history in the same cycle");
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job pushed into a full queue");
    a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from an empty queue");

endmodule

### bench/range_image_despeckle_3x3_tb.sv
// Self-checking bench for the streaming 3x3 range image despeckle filter.
// Depends on drsp_pkg and range_image_despeckle_3x3; holds its own predictor.
`timescale 1ns / 100ps

module range_image_despeckle_3x3_tb;

    localparam int HIST_DEPTH = 2 * drsp_pkg::MAX_WIDTH_DEF + 4;
    localparam logic [drsp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 200;
    localparam int LONG_HOLD = 300;

    typedef struct {
        logic [drsp_pkg::PIX_W-1:0] pix;
        logic                       last;
    } despeckled_t;

    typedef struct {
        logic                       req;
        logic [drsp_pkg::PIX_W-1:0] pix;
        bit                         typed;
        bit                         want_out;
        logic [drsp_pkg::PIX_W-1:0] want_pix;
        logic                       want_last;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic req_type = drsp_pkg::REQ_PIXEL;
    logic [drsp_pkg::PIX_W-1:0] pixel_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [drsp_pkg::PIX_W-1:0] pixel_out;
    logic frame_last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [drsp_pkg::CFG_IDX_W-1:0] cfg_index = drsp_pkg::CFG_THRESH;
    logic [drsp_pkg::PIX_W-1:0] cfg_data = '0;

    range_image_despeckle_3x3 dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .pixel_in(pixel_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .pixel_out(pixel_out), .frame_last(frame_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #8ms;
        $display("Verification failed");
        $finish;
    end

    // predictor state
    logic [drsp_pkg::PIX_W-1:0]  hist [HIST_DEPTH];
    int unsigned                 wr_ptr, col_pos, row_pos, held_cnt;
    logic [drsp_pkg::PIX_W-1:0]  thr_reg = drsp_pkg::THRESH_RST;
    logic [drsp_pkg::WREG_W-1:0] wid_reg = drsp_pkg::WIDTH_RST;
    logic [drsp_pkg::HREG_W-1:0] hgt_reg = drsp_pkg::HEIGHT_RST;

    despeckled_t despeckled_q[$];
    int  mismatches = 0;
    bit  calm = 1'b0;
    bit  hold_long = 1'b0;

    function automatic int unsigned hist_back(int unsigned o);
        return (wr_ptr + HIST_DEPTH - 1 - (o % HIST_DEPTH)) % HIST_DEPTH;
    endfunction

    function automatic int unsigned eff_width();
        if (wid_reg < 3) return 3;
        if (wid_reg > drsp_pkg::MAX_WIDTH_DEF) return drsp_pkg::MAX_WIDTH_DEF;
        return wid_reg;
    endfunction

    function automatic logic [drsp_pkg::PIX_W-1:0] despeckle(int unsigned w);
        int unsigned t, mn, mx, me, v;
        int o;
        t = (thr_reg == 0) ? 1 : thr_reg;
        mn = 32'hFFFF;
        mx = 0;
        me = hist[hist_back(w + 1)];
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
            begin
                if (dy == 0 && dx == 0) continue;
                o = int'(w) + 1 - dx - dy * int'(w);
                v = hist[hist_back(o)];
                if (v < mn) mn = v;
                if (v > mx) mx = v;
            end
        if (mn > me && mn - me > t)
            me += ((mn - me - 1) / t) * t;
        else if (me > mx && me - mx > t)
            me -= ((me - mx - 1) / t) * t;
        return me[drsp_pkg::PIX_W-1:0];
    endfunction

    task automatic predict_item(input logic rq, input logic [drsp_pkg::PIX_W-1:0] px,
                                output bit got, output despeckled_t res);
        int unsigned w, h, f, p, q, qr, qc, a;
        w = eff_width();
        h = (hgt_reg < 3) ? 3 : hgt_reg;
        f = w * h;
        p = row_pos * w + col_pos;
        got = 1'b0;
        if (p >= f)
        begin
            col_pos = 0; row_pos = 0; held_cnt = 0; p = 0;
        end
        if (rq == drsp_pkg::REQ_FLUSH)
        begin
            if (held_cnt == 0) return;
            q = (p + f - held_cnt) % f;
            res.pix = hist[hist_back(held_cnt - 1)];
            res.last = (q == f - 1);
            held_cnt--;
            got = 1'b1;
            return;
        end
        hist[wr_ptr] = px;
        wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
        if (held_cnt < w + 1)
        begin
            held_cnt++;
            return;
        end
        q = (p + f - (w + 1)) % f;
        qr = q / w;
        qc = q % w;
        a = hist_back(w + 1);
        if (qr == 0 || qr == h - 1 || qc == 0 || qc == w - 1)
            res.pix = hist[a];
        else
        begin
            res.pix = despeckle(w);
            hist[a] = res.pix;
        end
        res.last = (q == f - 1);
        got = 1'b1;
    endtask

    // offer one item; a typed row overrides the predicted result
    task automatic send_item(input logic rq, input logic [drsp_pkg::PIX_W-1:0] px,
                             input bit typed = 0, input bit want_out = 0,
                             input logic [drsp_pkg::PIX_W-1:0] want_pix = '0,
                             input logic want_last = 0);
        bit got;
        despeckled_t res;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        pixel_in <= px;
        do @(posedge clk); while (!in_ready);
        predict_item(rq, px, got, res);
        if (typed)
        begin
            got = want_out;
            res.pix = want_pix;
            res.last = want_last;
        end
        if (got) despeckled_q.push_back(res);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (despeckled_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [drsp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [drsp_pkg::PIX_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            drsp_pkg::CFG_THRESH: thr_reg = val;
            drsp_pkg::CFG_WIDTH:  wid_reg = val[drsp_pkg::WREG_W-1:0];
            drsp_pkg::CFG_HEIGHT: hgt_reg = val;
            default:              return;
        endcase
        col_pos = 0;
        row_pos = 0;
        held_cnt = 0;
    endtask

    task automatic configure(input logic [drsp_pkg::PIX_W-1:0] t,
                             input logic [drsp_pkg::PIX_W-1:0] w,
                             input logic [drsp_pkg::PIX_W-1:0] h);
        wait_drained();
        write_reg(drsp_pkg::CFG_THRESH, t);
        write_reg(drsp_pkg::CFG_WIDTH, w);
        write_reg(drsp_pkg::CFG_HEIGHT, h);
    endtask

    // mostly whole frames of smooth surface with speckles, some flushes and noise
    task automatic random_phase(input int n_items);
        int sent, w, h, base, mode;
        logic [drsp_pkg::PIX_W-1:0] px;
        sent = 0;
        w = eff_width();
        h = (hgt_reg < 3) ? 3 : hgt_reg;
        while (sent < n_items)
        begin
            mode = $urandom_range(0, 9);
            base = $urandom_range(0, 65535);
            if (mode < 8)
            begin
                for (int i = 0; i < w * h && sent < n_items; i++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        px = drsp_pkg::PIX_W'($urandom_range(0, 65535));
                    else
                        px = drsp_pkg::PIX_W'(base + $urandom_range(0, 300));
                    send_item(drsp_pkg::REQ_PIXEL, px);
                    sent++;
                end
                if ($urandom_range(0, 1) == 1)
                    for (int i = 0; i < w + 1 && sent < n_items; i++)
                    begin
                        send_item(drsp_pkg::REQ_FLUSH,
                                  drsp_pkg::PIX_W'($urandom_range(0, 65535)));
                        sent++;
                    end
            end
            else if (mode == 8)
            begin
                repeat ($urandom_range(1, 5))
                begin
                    send_item(drsp_pkg::REQ_FLUSH,
                              drsp_pkg::PIX_W'($urandom_range(0, 65535)));
                    sent++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    send_item(1'($urandom_range(0, 1)),
                              drsp_pkg::PIX_W'($urandom_range(0, 65535)));
                    sent++;
                end
            end
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int hold;
        despeckled_t exp_res;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (despeckled_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: pixel_out=%0d frame_last=%0b",
                                 pixel_out, frame_last);
                end
                else
                begin
                    exp_res = despeckled_q.pop_front();
                    if (pixel_out !== exp_res.pix || frame_last !== exp_res.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: pixel_out=%0d/%0d frame_last=%0b/%0b (got/exp)",
                                     pixel_out, exp_res.pix, frame_last, exp_res.last);
                    end
                end
            end
            if (hold_long)
            begin
                hold_long = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                hold = $urandom_range(1, 6) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    stim_row_t directed [] = '{
        '{drsp_pkg::REQ_FLUSH, 16'd77,    1, 0, 16'd0,     1'b0},
        '{drsp_pkg::REQ_PIXEL, 16'hFFFF,  1, 0, 16'd0,     1'b0},
        '{drsp_pkg::REQ_PIXEL, 16'hFFFF,  1, 0, 16'd0,     1'b0},
        '{drsp_pkg::REQ_PIXEL, 16'hFFFF,  1, 0, 16'd0,     1'b0},
        '{drsp_pkg::REQ_PIXEL, 16'hFFFF,  1, 0, 16'd0,     1'b0},
        '{drsp_pkg::REQ_PIXEL, 16'd0,     1, 1, 16'hFFFF,  1'b0},
        '{drsp_pkg::REQ_PIXEL, 16'hFFFF,  1, 1, 16'hFFFF,  1'b0},
        '{drsp_pkg::REQ_PIXEL, 16'hFFFF,  1, 1, 16'hFFFF,  1'b0},
        '{drsp_pkg::REQ_PIXEL, 16'hFFFF,  1, 1, 16'hFFFF,  1'b0},
        '{drsp_pkg::REQ_PIXEL, 16'hFFFF,  0, 0, 16'd0,     1'b0},
        '{drsp_pkg::REQ_PIXEL, 16'd0,     1, 1, 16'hFFFF,  1'b0},
        '{drsp_pkg::REQ_PIXEL, 16'd0,     1, 1, 16'hFFFF,  1'b0},
        '{drsp_pkg::REQ_PIXEL, 16'd0,     1, 1, 16'hFFFF,  1'b0},
        '{drsp_pkg::REQ_PIXEL, 16'd0,     1, 1, 16'hFFFF,  1'b1},
        '{drsp_pkg::REQ_PIXEL, 16'hFFFF,  1, 1, 16'd0,     1'b0},
        '{drsp_pkg::REQ_PIXEL, 16'd0,     1, 1, 16'd0,     1'b0},
        '{drsp_pkg::REQ_PIXEL, 16'd0,     1, 1, 16'd0,     1'b0},
        '{drsp_pkg::REQ_PIXEL, 16'd0,     1, 1, 16'd0,     1'b0},
        '{drsp_pkg::REQ_PIXEL, 16'd0,     0, 0, 16'd0,     1'b0},
        '{drsp_pkg::REQ_FLUSH, 16'd0,     1, 1, 16'd0,     1'b0},
        '{drsp_pkg::REQ_FLUSH, 16'hFFFF,  1, 1, 16'd0,     1'b0},
        '{drsp_pkg::REQ_FLUSH, 16'd0,     1, 1, 16'd0,     1'b0},
        '{drsp_pkg::REQ_FLUSH, 16'd0,     1, 1, 16'd0,     1'b1},
        '{drsp_pkg::REQ_FLUSH, 16'd5,     1, 0, 16'd0,     1'b0}
    };

    initial
    begin
        for (int i = 0; i < HIST_DEPTH; i++) hist[i] = '0;
        wr_ptr = 0; col_pos = 0; row_pos = 0; held_cnt = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 frames: raise a pit, lower a spike, frame change without flush
        configure(16'd1, 16'd3, 16'd3);
        foreach (directed[i])
            send_item(directed[i].req, directed[i].pix, directed[i].typed,
                      directed[i].want_out, directed[i].want_pix, directed[i].want_last);

        // zero threshold, width and height below range
        configure(16'd0, 16'd0, 16'd0);
        write_reg(CFG_SPARE, 16'hFFFF);
        random_phase(60);

        // long output hold-off while input keeps coming
        configure(16'd40, 16'd5, 16'd4);
        hold_long = 1'b1;
        random_phase(80);

        // pause input until everything has come out, then resume
        configure(16'hFFFF, 16'd4, 16'hFFFF);
        random_phase(40);
        in_valid <= 1'b0;
        while (despeckled_q.size() != 0) @(posedge clk);
        random_phase(40);

        // widest row: width register all ones clamps to the maximum
        configure(16'd300, 16'hFFFF, 16'd3);
        for (int i = 0; i < drsp_pkg::MAX_WIDTH_DEF + 6; i++)
            send_item(drsp_pkg::REQ_PIXEL, drsp_pkg::PIX_W'($urandom_range(0, 65535)));

        configure(16'd1024, 16'd1024, 16'd3);
        random_phase(20);

        repeat (4)
        begin
            configure(drsp_pkg::PIX_W'($urandom_range(1, 2000)),
                      drsp_pkg::PIX_W'($urandom_range(3, 8)),
                      drsp_pkg::PIX_W'($urandom_range(3, 6)));
            random_phase(50);
        end

        // no idling at the end
        configure(16'd200, 16'd6, 16'd5);
        calm = 1'b1;
        random_phase(60);

        in_valid <= 1'b0;
        while (despeckled_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && despeckled_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
